[rtl/vlsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsm_pkg
// Shared types and constants for the video link status monitor.
// ----------------------------------------------------------------------------
package vlsm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_KIND       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_HOLD_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CABLE_LOSS_LIMIT = 2'd2;

    localparam logic       RST_BOARD_KIND       = 1'b0;
    localparam logic [3:0] RST_LOCK_HOLD_LIMIT  = 4'd5;
    localparam logic [3:0] RST_CABLE_LOSS_LIMIT = 4'd3;

    localparam logic [3:0] NO_TIMING_MAX = 4'd15;

    localparam logic [7:0] IVAL_30_120 = 8'h78;
    localparam logic [7:0] IVAL_60     = 8'h3C;
    localparam logic [7:0] FLAGS_120   = 8'h10;

    localparam logic [6:0] FPS_NONE = 7'd0;
    localparam logic [6:0] FPS_30   = 7'd30;
    localparam logic [6:0] FPS_60   = 7'd60;
    localparam logic [6:0] FPS_120  = 7'd120;

    localparam logic [1:0] CSPACE_MAX_DEFINED = 2'd2;
    localparam logic [1:0] CSPACE_UNDEFINED   = 2'd3;
    localparam logic [1:0] CMETRY_UNDEFINED   = 2'd0;

    typedef enum logic [1:0] {
        STATUS_UPDATED  = 2'd0,
        STATUS_READ_ERR = 2'd1,
        STATUS_HELD     = 2'd2
    } t_status;

    typedef struct packed {
        logic        read_ok;
        logic [15:0] total_lines_v;
        logic [15:0] total_pixels_h;
        logic [15:0] active_rows;
        logic [15:0] active_cols;
        logic [7:0]  interval_hint;
        logic [7:0]  flag_byte;
        logic [7:0]  space_code;
    } t_vlsm_in;

    typedef struct packed {
        t_status     status;
        logic        is_locked;
        logic        cable_present;
        logic [15:0] out_width;
        logic [16:0] out_height;
        logic        out_interlaced;
        logic [1:0]  out_colorimetry;
        logic [1:0]  out_colorspace;
        logic [6:0]  fps_hint;
        logic [15:0] out_total_h;
        logic [15:0] out_total_v;
        logic        resync;
    } t_vlsm_out;

endpackage

[rtl/video_link_status_monitor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_link_status_monitor_unit
// Debounces receiver lock and cable state and decodes the active format
// from polled status reports.
// ----------------------------------------------------------------------------
// One status report per clock. Each accepted transaction is decoded against
// the stored link state combinationally and its result appears in the
// output register on the next cycle; the state update and the result are
// written together, so a new report may be accepted every cycle. The input
// stalls only while the output register is full and the output is stalled.
// Configuration writes take effect on the next report.
module video_link_status_monitor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vlsm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vlsm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  vlsm_pkg::t_vlsm_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output vlsm_pkg::t_vlsm_out                 o_out_data
);
    import vlsm_pkg::*;

    logic        r_board_kind;
    logic [3:0]  r_hold_limit;
    logic [3:0]  r_loss_limit;

    logic        r_lock,        n_lock;
    logic        r_cable,       n_cable;
    logic [3:0]  r_dropout,     n_dropout;
    logic [3:0]  r_no_timing,   n_no_timing;
    logic [15:0] r_total_h,     n_total_h;
    logic [15:0] r_total_v,     n_total_v;
    logic [7:0]  r_interval,    n_interval;
    logic [7:0]  r_flags,       n_flags;
    logic [15:0] r_width,       n_width;
    logic [16:0] r_height,      n_height;
    logic        r_interlace,   n_interlace;
    logic [1:0]  r_colorimetry, n_colorimetry;
    logic [1:0]  r_colorspace,  n_colorspace;

    logic        r_out_valid;
    t_vlsm_out   r_out,         n_out;

    logic        in_accept;
    logic        timing;
    logic        locked;
    logic        changed;
    logic        resync;
    logic [3:0]  no_timing_inc;
    t_status     status;
    logic [6:0]  fps;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign timing = (i_in_data.total_lines_v | i_in_data.total_pixels_h) != 16'd0;

    always_comb begin
        n_lock        = r_lock;
        n_cable       = r_cable;
        n_dropout     = r_dropout;
        n_no_timing   = r_no_timing;
        n_total_h     = r_total_h;
        n_total_v     = r_total_v;
        n_interval    = r_interval;
        n_flags       = r_flags;
        n_width       = r_width;
        n_height      = r_height;
        n_interlace   = r_interlace;
        n_colorimetry = r_colorimetry;
        n_colorspace  = r_colorspace;
        status        = STATUS_UPDATED;
        fps           = FPS_NONE;
        resync        = 1'b0;
        changed       = 1'b0;
        locked        = 1'b0;
        no_timing_inc = (r_no_timing < NO_TIMING_MAX) ? r_no_timing + 4'd1 : r_no_timing;

        priority if (!i_in_data.read_ok) begin
            status = STATUS_READ_ERR;
        end else if (r_board_kind && !timing && r_lock && (r_dropout < r_hold_limit)) begin
            status    = STATUS_HELD;
            n_dropout = r_dropout + 4'd1;
        end else begin
            if (r_board_kind) begin
                locked = timing;
                if (timing) begin
                    n_dropout = 4'd0;
                end
            end else begin
                locked = i_in_data.active_rows[7:0] != 8'd0;
            end

            if (locked) begin
                changed = r_lock && (r_total_h != 16'd0) && (r_total_v != 16'd0) &&
                          ((i_in_data.total_pixels_h != r_total_h) ||
                           (i_in_data.total_lines_v != r_total_v) ||
                           (i_in_data.interval_hint != r_interval) ||
                           (i_in_data.flag_byte != r_flags));
                resync        = changed | ~r_lock;
                n_lock        = 1'b1;
                n_cable       = 1'b1;
                n_no_timing   = 4'd0;
                n_colorimetry = i_in_data.flag_byte[5:4];
                n_colorspace  = (i_in_data.space_code <= {6'd0, CSPACE_MAX_DEFINED}) ?
                                i_in_data.space_code[1:0] : CSPACE_UNDEFINED;
                n_interval    = i_in_data.interval_hint;
                n_flags       = i_in_data.flag_byte;
                n_width       = i_in_data.active_cols;
                n_total_v     = i_in_data.total_lines_v;
                n_total_h     = i_in_data.total_pixels_h;
                n_interlace   = i_in_data.flag_byte[0];
                n_height      = i_in_data.flag_byte[0] ? {i_in_data.active_rows, 1'b0} :
                                                         {1'b0, i_in_data.active_rows};
                if (resync) begin
                    priority if (i_in_data.interval_hint == IVAL_30_120) begin
                        fps = (i_in_data.flag_byte == FLAGS_120) ? FPS_120 : FPS_30;
                    end else if (i_in_data.interval_hint == IVAL_60) begin
                        fps = FPS_60;
                    end else begin
                        fps = FPS_NONE;
                    end
                end
            end else begin
                n_cable = 1'b1;
                if (timing) begin
                    n_no_timing = 4'd0;
                end else begin
                    n_no_timing = no_timing_inc;
                end
                if (timing || (no_timing_inc >= r_loss_limit)) begin
                    n_cable       = timing;
                    n_lock        = 1'b0;
                    n_width       = 16'd0;
                    n_height      = 17'd0;
                    n_total_h     = 16'd0;
                    n_total_v     = 16'd0;
                    n_interlace   = 1'b0;
                    n_colorimetry = CMETRY_UNDEFINED;
                    n_colorspace  = CSPACE_UNDEFINED;
                end
            end
        end

        n_out.status          = status;
        n_out.is_locked       = n_lock;
        n_out.cable_present   = n_cable;
        n_out.out_width       = n_width;
        n_out.out_height      = n_height;
        n_out.out_interlaced  = n_interlace;
        n_out.out_colorimetry = n_colorimetry;
        n_out.out_colorspace  = n_colorspace;
        n_out.fps_hint        = fps;
        n_out.out_total_h     = n_total_h;
        n_out.out_total_v     = n_total_v;
        n_out.resync          = resync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_kind <= RST_BOARD_KIND;
            r_hold_limit <= RST_LOCK_HOLD_LIMIT;
            r_loss_limit <= RST_CABLE_LOSS_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOARD_KIND:       r_board_kind <= i_cfg_data[0];
                CFG_LOCK_HOLD_LIMIT:  r_hold_limit <= i_cfg_data;
                CFG_CABLE_LOSS_LIMIT: r_loss_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock        <= 1'b0;
            r_cable       <= 1'b0;
            r_dropout     <= 4'd0;
            r_no_timing   <= 4'd0;
            r_total_h     <= 16'd0;
            r_total_v     <= 16'd0;
            r_interval    <= 8'd0;
            r_flags       <= 8'd0;
            r_width       <= 16'd0;
            r_height      <= 17'd0;
            r_interlace   <= 1'b0;
            r_colorimetry <= CMETRY_UNDEFINED;
            r_colorspace  <= CSPACE_UNDEFINED;
        end else if (in_accept) begin
            r_lock        <= n_lock;
            r_cable       <= n_cable;
            r_dropout     <= n_dropout;
            r_no_timing   <= n_no_timing;
            r_total_h     <= n_total_h;
            r_total_v     <= n_total_v;
            r_interval    <= n_interval;
            r_flags       <= n_flags;
            r_width       <= n_width;
            r_height      <= n_height;
            r_interlace   <= n_interlace;
            r_colorimetry <= n_colorimetry;
            r_colorspace  <= n_colorspace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

endmodule
